// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the command encoder RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MCCE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define MCCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCCE_ASSERT(lbl, expr)
`define MCCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mcce_pkg.sv =====
// Types, codes and constants of the motor CAN command encoder.
// No dependencies; the modules and the testbench refer to it by scoped names.
`timescale 1ns / 1ps
package mcce_pkg;

  typedef enum logic [2:0] {
    OP_MIT         = 3'd0,
    OP_SPEED       = 3'd1,
    OP_POS_SPEED   = 3'd2,
    OP_ENABLE      = 3'd3,
    OP_DISABLE     = 3'd4,
    OP_ENABLE_ALL  = 3'd5,
    OP_DISABLE_ALL = 3'd6,
    OP_MODE_CHANGE = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    REG_POSITION_LIMIT = 3'd0,
    REG_VELOCITY_LIMIT = 3'd1,
    REG_TORQUE_LIMIT   = 3'd2,
    REG_STIFFNESS_MAX  = 3'd3,
    REG_DAMPING_MAX    = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         motor_slot;
    logic signed [23:0] mit_position;
    logic signed [23:0] mit_velocity;
    logic [24:0]        mit_stiffness;
    logic [19:0]        mit_damping;
    logic signed [23:0] mit_torque;
    logic [31:0]        target_position_word;
    logic [31:0]        target_velocity_word;
    logic [1:0]         mode_sel;
  } in_word_t;

  typedef struct packed {
    logic [10:0] can_id;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    op_e         op;
    logic [4:0]  base;
    logic [31:0] pos_word;
    logic [31:0] vel_word;
    logic [1:0]  mode;
  } cmd_t;

  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int QUOT_W         = DIV_STAGES * BITS_PER_STAGE;
  localparam int OFF_W          = 25;
  localparam int NUM_W          = OFF_W + QUOT_W;
  localparam int LATENCY        = 2 + DIV_STAGES;
  localparam int FRAME_CAP      = 6;
  localparam int MODE_FRAMES    = 4;

  localparam logic [10:0] ID_BROADCAST = 11'h7FF;
  localparam logic [10:0] ID_OFS_SPEED = 11'h200;
  localparam logic [10:0] ID_OFS_POS   = 11'h100;
  localparam logic [63:0] PAT_ENABLE   = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [63:0] PAT_DISABLE  = 64'hFFFF_FFFF_FFFF_FFFD;
  localparam logic [7:0]  MODE_SET_KEY = 8'h55;
  localparam logic [7:0]  MODE_SET_REG = 8'h0A;
  localparam logic [7:0]  SAVE_KEY     = 8'hAA;
  localparam logic [7:0]  SAVE_REG     = 8'h01;

  localparam logic [22:0] POSITION_LIMIT_RST = 23'd819200;
  localparam logic [22:0] VELOCITY_LIMIT_RST = 23'd1966080;
  localparam logic [22:0] TORQUE_LIMIT_RST   = 23'd655360;
  localparam logic [24:0] STIFFNESS_MAX_RST  = 25'd32768000;
  localparam logic [19:0] DAMPING_MAX_RST    = 20'd327680;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/core/motor_can_command_encoder_top.sv =====
// Top level of the motor CAN command encoder: limit registers, command pipeline.
// Depends on mcce_pkg, mcce_lane, mcce_framer and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Each kept command word becomes one or more CAN frame words. A command can enter
// every cycle while in_stall is low; its first frame passes 8 register stages (2
// scaling stages, 4 divider stages of 4 quotient bits each, frame expander, output
// register). While out_stall is low, single-frame commands sustain one per cycle;
// a mode change occupies the frame expander for 4 frames and a broadcast enable or
// disable for min(MOTOR_COUNT, 6), one frame per cycle, stalling the input for all
// but one of them. Non-broadcast commands addressed at or above MOTOR_COUNT are
// dropped. cfg_ready is always high; write limits only while the block is idle.
module motor_can_command_encoder_top #(
  parameter int MOTOR_COUNT = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcce_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output mcce_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int LAT = mcce_pkg::LATENCY;
  localparam int OW  = mcce_pkg::OFF_W;

  logic [22:0] position_limit_r, velocity_limit_r, torque_limit_r;
  logic [24:0] stiffness_max_r;
  logic [19:0] damping_max_r;

  logic           en, keep, take;
  mcce_pkg::op_e  op_in;
  mcce_pkg::cmd_t cmd_in;
  logic           vld_r [LAT];
  mcce_pkg::cmd_t cmd_r [LAT];
  logic [15:0]    code_pos;
  logic [11:0]    code_vel, code_kp, code_kd, code_tor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_limit_r <= mcce_pkg::POSITION_LIMIT_RST;
      velocity_limit_r <= mcce_pkg::VELOCITY_LIMIT_RST;
      torque_limit_r   <= mcce_pkg::TORQUE_LIMIT_RST;
      stiffness_max_r  <= mcce_pkg::STIFFNESS_MAX_RST;
      damping_max_r    <= mcce_pkg::DAMPING_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcce_pkg::REG_POSITION_LIMIT:
          position_limit_r <= (cfg_data[22:0] == '0) ? 23'd1 : cfg_data[22:0];
        mcce_pkg::REG_VELOCITY_LIMIT:
          velocity_limit_r <= (cfg_data[22:0] == '0) ? 23'd1 : cfg_data[22:0];
        mcce_pkg::REG_TORQUE_LIMIT:
          torque_limit_r <= (cfg_data[22:0] == '0) ? 23'd1 : cfg_data[22:0];
        mcce_pkg::REG_STIFFNESS_MAX:
          stiffness_max_r <= (cfg_data[24:0] == '0) ? 25'd1 : cfg_data[24:0];
        mcce_pkg::REG_DAMPING_MAX:
          damping_max_r <= (cfg_data[19:0] == '0) ? 20'd1 : cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign en       = !vld_r[LAT-1] || take;
  assign in_stall = !en;

  assign op_in = mcce_pkg::op_e'(in_word.operation);
  assign keep  = (op_in == mcce_pkg::OP_ENABLE_ALL) || (op_in == mcce_pkg::OP_DISABLE_ALL) ||
                 (in_word.motor_slot < 4'(MOTOR_COUNT));

  always_comb begin
    cmd_in.op       = op_in;
    cmd_in.base     = {1'b0, in_word.motor_slot} + 5'd1;
    cmd_in.pos_word = in_word.target_position_word;
    cmd_in.vel_word = in_word.target_velocity_word;
    cmd_in.mode     = in_word.mode_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid && keep;
      for (int s = 1; s < LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0] <= cmd_in;
      for (int s = 1; s < LAT; s++) begin
        cmd_r[s] <= cmd_r[s-1];
      end
    end
  end

  mcce_lane #(.CODE_BITS(16)) u_lane_pos (
    .clk     (clk),
    .en      (en),
    .value_i (26'(in_word.mit_position)),
    .bias_i  ({2'b00, position_limit_r}),
    .span_i  ({1'b0, position_limit_r, 1'b0}),
    .code_o  (code_pos)
  );

  mcce_lane #(.CODE_BITS(12)) u_lane_vel (
    .clk     (clk),
    .en      (en),
    .value_i (26'(in_word.mit_velocity)),
    .bias_i  ({2'b00, velocity_limit_r}),
    .span_i  ({1'b0, velocity_limit_r, 1'b0}),
    .code_o  (code_vel)
  );

  mcce_lane #(.CODE_BITS(12)) u_lane_kp (
    .clk     (clk),
    .en      (en),
    .value_i ({1'b0, in_word.mit_stiffness}),
    .bias_i  ('0),
    .span_i  (stiffness_max_r),
    .code_o  (code_kp)
  );

  mcce_lane #(.CODE_BITS(12)) u_lane_kd (
    .clk     (clk),
    .en      (en),
    .value_i ({6'b0, in_word.mit_damping}),
    .bias_i  ('0),
    .span_i  ({{(OW-20){1'b0}}, damping_max_r}),
    .code_o  (code_kd)
  );

  mcce_lane #(.CODE_BITS(12)) u_lane_tor (
    .clk     (clk),
    .en      (en),
    .value_i (26'(in_word.mit_torque)),
    .bias_i  ({2'b00, torque_limit_r}),
    .span_i  ({1'b0, torque_limit_r, 1'b0}),
    .code_o  (code_tor)
  );

  mcce_framer #(.MOTOR_COUNT(MOTOR_COUNT)) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (vld_r[LAT-1]),
    .cmd_i     (cmd_r[LAT-1]),
    .mit_i     ({code_pos, code_vel, code_kp, code_kd, code_tor}),
    .take_o    (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  `MCCE_ASSERT(a_stall_needs_full_tail, !in_stall || vld_r[LAT-1])
  `MCCE_ASSERT(a_limits_nonzero, (position_limit_r != '0) && (velocity_limit_r != '0) &&
    (torque_limit_r != '0) && (stiffness_max_r != '0) && (damping_max_r != '0))
  `MCCE_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall && keep, vld_r[0])

endmodule

// ===== rtl/core/mcce_lane.sv =====
// One scaling lane: offset and saturation, numerator, then a pipelined divider.
// Depends on mcce_pkg; the enable moves all stages together.
`timescale 1ns / 1ps
module mcce_lane #(
  parameter int CODE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [25:0]          value_i,
  input  logic [mcce_pkg::OFF_W-1:0]  bias_i,
  input  logic [mcce_pkg::OFF_W-1:0]  span_i,
  output logic [CODE_BITS-1:0]        code_o
);

  localparam int OW = mcce_pkg::OFF_W;
  localparam int QW = mcce_pkg::QUOT_W;
  localparam int NW = mcce_pkg::NUM_W;
  localparam int DS = mcce_pkg::DIV_STAGES;
  localparam int BS = mcce_pkg::BITS_PER_STAGE;

  logic signed [OW+1:0] off;
  logic                 sat_lo, sat_hi;
  logic [OW-1:0]        off_a_r, off_a_nxt, span_a_r;
  logic                 sat_a_r;
  logic [NW-1:0]        ext_b, prod_b, num_b_nxt, num_b_r;
  logic [OW-1:0]        span_b_r;
  logic                 sat_b_r;
  logic [OW-1:0]        rem_r  [DS];
  logic [QW-1:0]        low_r  [DS];
  logic [QW-1:0]        quo_r  [DS];
  logic [OW-1:0]        span_r [DS];
  logic                 sat_r  [DS];

  assign off    = $signed({value_i[25], value_i}) + $signed({2'b00, bias_i});
  assign sat_lo = off[OW+1] || (off == '0);
  assign sat_hi = !sat_lo && (off[OW:0] >= {1'b0, span_i});
  assign off_a_nxt = (sat_lo || sat_hi) ? '0 : off[OW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      off_a_r  <= off_a_nxt;
      span_a_r <= span_i;
      sat_a_r  <= sat_hi;
    end
  end

  assign ext_b     = {{QW{1'b0}}, off_a_r};
  assign prod_b    = (ext_b << CODE_BITS) - ext_b;
  assign num_b_nxt = prod_b << (QW - CODE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      num_b_r  <= num_b_nxt;
      span_b_r <= span_a_r;
      sat_b_r  <= sat_a_r;
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [OW-1:0] rem_in, rem_nxt, span_in;
    logic [QW-1:0] low_in, low_nxt, quo_in, quo_nxt;
    logic          sat_in;
    logic [OW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = num_b_r[NW-1:QW];
      assign low_in  = num_b_r[QW-1:0];
      assign quo_in  = '0;
      assign span_in = span_b_r;
      assign sat_in  = sat_b_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign span_in = span_r[k-1];
      assign sat_in  = sat_r[k-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      low_nxt = low_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int j = 0; j < BS; j++) begin
        trial   = {rem_nxt, low_nxt[QW-1]};
        low_nxt = {low_nxt[QW-2:0], 1'b0};
        if (trial >= {1'b0, span_in}) begin
          trial   = trial - {1'b0, span_in};
          quo_nxt = {quo_nxt[QW-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QW-2:0], 1'b0};
        end
        rem_nxt = trial[OW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        low_r[k]  <= low_nxt;
        quo_r[k]  <= quo_nxt;
        span_r[k] <= span_in;
        sat_r[k]  <= sat_in;
      end
    end
  end

  assign code_o = sat_r[DS-1] ? {CODE_BITS{1'b1}} : quo_r[DS-1][QW-1 -: CODE_BITS];

endmodule

// ===== rtl/core/mcce_framer.sv =====
// Frame expander and output register: turns one command into its CAN frames.
// Depends on mcce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcce_framer #(
  parameter int MOTOR_COUNT = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  mcce_pkg::cmd_t      cmd_i,
  input  logic [63:0]         mit_i,
  output logic                take_o,
  output logic                out_valid,
  input  logic                out_stall,
  output mcce_pkg::out_word_t out_word
);

  localparam int BC_FRAMES = (MOTOR_COUNT < mcce_pkg::FRAME_CAP) ? MOTOR_COUNT
                                                                 : mcce_pkg::FRAME_CAP;

  logic                hold_v_r, hold_v_nxt;
  mcce_pkg::cmd_t      hold_r;
  logic [63:0]         mit_r;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [2:0]          frames;
  logic                load, emit, frame_last;
  mcce_pkg::out_word_t frame;
  logic                out_valid_r;
  mcce_pkg::out_word_t out_word_r;
  logic [63:0]         head;

  always_comb begin
    unique case (hold_r.op)
      mcce_pkg::OP_ENABLE_ALL, mcce_pkg::OP_DISABLE_ALL: frames = 3'(BC_FRAMES);
      mcce_pkg::OP_MODE_CHANGE:                          frames = 3'(mcce_pkg::MODE_FRAMES);
      default:                                           frames = 3'd1;
    endcase
  end

  assign frame_last = (cnt_r == frames - 3'd1);
  assign head       = {8'(hold_r.base), 8'h00, 48'h0};

  always_comb begin
    frame.can_id     = 11'(hold_r.base);
    frame.payload    = mcce_pkg::PAT_ENABLE;
    frame.byte_count = 4'd8;
    frame.last       = frame_last;
    unique case (hold_r.op)
      mcce_pkg::OP_MIT: frame.payload = mit_r;
      mcce_pkg::OP_SPEED: begin
        frame.can_id     = 11'(hold_r.base) + mcce_pkg::ID_OFS_SPEED;
        frame.payload    = {mcce_pkg::swap32(hold_r.vel_word), 32'h0};
        frame.byte_count = 4'd4;
      end
      mcce_pkg::OP_POS_SPEED: begin
        frame.can_id  = 11'(hold_r.base) + mcce_pkg::ID_OFS_POS;
        frame.payload = {mcce_pkg::swap32(hold_r.pos_word),
                         mcce_pkg::swap32(hold_r.vel_word)};
      end
      mcce_pkg::OP_ENABLE:  frame.payload = mcce_pkg::PAT_ENABLE;
      mcce_pkg::OP_DISABLE: frame.payload = mcce_pkg::PAT_DISABLE;
      mcce_pkg::OP_ENABLE_ALL: begin
        frame.can_id  = 11'(cnt_r) + 11'd1;
        frame.payload = mcce_pkg::PAT_ENABLE;
      end
      mcce_pkg::OP_DISABLE_ALL: begin
        frame.can_id  = 11'(cnt_r) + 11'd1;
        frame.payload = mcce_pkg::PAT_DISABLE;
      end
      mcce_pkg::OP_MODE_CHANGE: begin
        case (cnt_r)
          3'd0: begin
            frame.can_id  = mcce_pkg::ID_BROADCAST;
            frame.payload = head | {16'h0, mcce_pkg::MODE_SET_KEY, mcce_pkg::MODE_SET_REG,
                                    6'h0, hold_r.mode, 24'h0};
          end
          3'd1: frame.payload = mcce_pkg::PAT_DISABLE;
          3'd2: begin
            frame.can_id  = mcce_pkg::ID_BROADCAST;
            frame.payload = head | {16'h0, mcce_pkg::SAVE_KEY, mcce_pkg::SAVE_REG, 32'h0};
          end
          default: frame.payload = mcce_pkg::PAT_ENABLE;
        endcase
      end
      default: frame.payload = mcce_pkg::PAT_ENABLE;
    endcase
  end

  assign load   = !out_valid_r || !out_stall;
  assign emit   = load && hold_v_r;
  assign take_o = !hold_v_r || (emit && frame_last);

  always_comb begin
    hold_v_nxt = hold_v_r;
    cnt_nxt    = cnt_r;
    if (take_o) begin
      hold_v_nxt = cmd_valid;
      cnt_nxt    = '0;
    end else if (emit) begin
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      cnt_r    <= cnt_nxt;
      if (load) begin
        out_valid_r <= hold_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      hold_r <= cmd_i;
      mit_r  <= mit_i;
    end
    if (load) begin
      out_word_r <= frame;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `MCCE_ASSERT(a_cnt_in_range, !hold_v_r || (cnt_r < frames))
  `MCCE_ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && !out_word.last, out_valid)
  `MCCE_ASSERT_NEXT(a_take_clears_count, take_o, cnt_r == 3'd0)

endmodule

// ===== verif/motor_can_command_encoder_top_test.sv =====
// Self-checking testbench for motor_can_command_encoder_top: drives commands and limit
// writes, predicts the CAN frame words in place and compares them in order.
// Depends on mcce_pkg and the RTL of the encoder.
`timescale 1ns / 1ps
module motor_can_command_encoder_top_test;

  localparam int MOTORS = 6;
  localparam int WATCHDOG = 20000;
  localparam int IN_W = $bits(mcce_pkg::in_word_t);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mcce_pkg::in_word_t in_word;
  logic out_valid;
  logic out_stall;
  mcce_pkg::out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  motor_can_command_encoder_top #(.MOTOR_COUNT(MOTORS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [22:0] lim_pos, lim_vel, lim_tor;
  logic [24:0] lim_kp;
  logic [19:0] lim_kd;

  mcce_pkg::in_word_t cmd_q[$];
  mcce_pkg::out_word_t frame_q[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit pause_send;
  bit in_acc;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] scale_code(longint off, longint span, int bits);
    longint top;
    top = (longint'(1) << bits) - 1;
    if (off <= 0) return '0;
    if (off >= span) return top[15:0];
    return 16'((off * top) / span);
  endfunction

  function automatic logic [31:0] byte_rev(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic mcce_pkg::out_word_t frame(logic [10:0] id, logic [63:0] pay,
                                                logic [3:0] cnt, logic lst);
    mcce_pkg::out_word_t f;
    f.can_id = id;
    f.payload = pay;
    f.byte_count = cnt;
    f.last = lst;
    return f;
  endfunction

  task automatic predict_frames(input mcce_pkg::in_word_t c);
    logic [10:0] base;
    logic [63:0] head;
    logic [15:0] p, v, kp, kd, t;
    base = 11'(c.motor_slot) + 11'd1;
    if (c.operation == mcce_pkg::OP_ENABLE_ALL || c.operation == mcce_pkg::OP_DISABLE_ALL) begin
      for (int i = 0; i < MOTORS && i < mcce_pkg::FRAME_CAP; i++)
        frame_q.push_back(frame(11'(i + 1),
          c.operation == mcce_pkg::OP_ENABLE_ALL ? mcce_pkg::PAT_ENABLE : mcce_pkg::PAT_DISABLE,
          4'd8, (i + 1 >= MOTORS || i + 1 >= mcce_pkg::FRAME_CAP)));
      return;
    end
    if (c.motor_slot >= MOTORS) return;
    case (c.operation)
      mcce_pkg::OP_MIT: begin
        p = scale_code(longint'(c.mit_position) + lim_pos, 2 * longint'(lim_pos), 16);
        v = scale_code(longint'(c.mit_velocity) + lim_vel, 2 * longint'(lim_vel), 12);
        kp = scale_code(longint'(c.mit_stiffness), longint'(lim_kp), 12);
        kd = scale_code(longint'(c.mit_damping), longint'(lim_kd), 12);
        t = scale_code(longint'(c.mit_torque) + lim_tor, 2 * longint'(lim_tor), 12);
        frame_q.push_back(frame(base, {p, v[11:0], kp[11:0], kd[11:0], t[11:0]}, 4'd8, 1'b1));
      end
      mcce_pkg::OP_SPEED: frame_q.push_back(frame(base + mcce_pkg::ID_OFS_SPEED,
        {byte_rev(c.target_velocity_word), 32'd0}, 4'd4, 1'b1));
      mcce_pkg::OP_POS_SPEED: frame_q.push_back(frame(base + mcce_pkg::ID_OFS_POS,
        {byte_rev(c.target_position_word), byte_rev(c.target_velocity_word)}, 4'd8, 1'b1));
      mcce_pkg::OP_ENABLE: frame_q.push_back(frame(base, mcce_pkg::PAT_ENABLE, 4'd8, 1'b1));
      mcce_pkg::OP_DISABLE: frame_q.push_back(frame(base, mcce_pkg::PAT_DISABLE, 4'd8, 1'b1));
      default: begin
        head = {base[7:0], 5'd0, base[10:8], 48'd0};
        frame_q.push_back(frame(mcce_pkg::ID_BROADCAST, head | {16'd0, mcce_pkg::MODE_SET_KEY,
          mcce_pkg::MODE_SET_REG, 6'd0, c.mode_sel, 24'd0}, 4'd8, 1'b0));
        frame_q.push_back(frame(base, mcce_pkg::PAT_DISABLE, 4'd8, 1'b0));
        frame_q.push_back(frame(mcce_pkg::ID_BROADCAST, head | {16'd0, mcce_pkg::SAVE_KEY,
          mcce_pkg::SAVE_REG, 32'd0}, 4'd8, 1'b0));
        frame_q.push_back(frame(base, mcce_pkg::PAT_ENABLE, 4'd8, 1'b1));
      end
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (cmd_q.size() > 0 && !pause_send && $urandom_range(99) >= send_idle_pct) begin
        in_word <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        predict_frames(in_word);
      end
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          report("unexpected word", {53'd0, out_word.can_id}, 64'd0);
        end else begin
          mcce_pkg::out_word_t w;
          w = frame_q.pop_front();
          if (out_word.can_id !== w.can_id) report("can_id", 64'(out_word.can_id), 64'(w.can_id));
          if (out_word.payload !== w.payload) report("payload", out_word.payload, w.payload);
          if (out_word.byte_count !== w.byte_count)
            report("byte_count", 64'(out_word.byte_count), 64'(w.byte_count));
          if (out_word.last !== w.last) report("last", 64'(out_word.last), 64'(w.last));
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("motor_can_command_encoder_top verification failed");
        $finish;
      end
    end else begin
      in_acc <= 1'b0;
    end
  end

  function automatic mcce_pkg::in_word_t rand_cmd(bit sane);
    mcce_pkg::in_word_t c;
    logic [191:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = r[IN_W-1:0];
    c.mode_sel = sane ? 2'($urandom_range(1, 3)) : 2'($urandom);
    if (sane) c.motor_slot = 4'($urandom_range(MOTORS - 1));
    if ($urandom_range(3) == 0) begin
      c.mit_position = 24'($signed($urandom_range(0, 2 * lim_pos)) - $signed({1'b0, lim_pos}));
      c.mit_velocity = 24'($signed($urandom_range(0, 2 * lim_vel)) - $signed({1'b0, lim_vel}));
      c.mit_torque = 24'($signed($urandom_range(0, 2 * lim_tor)) - $signed({1'b0, lim_tor}));
      c.mit_stiffness = 25'($urandom_range(0, lim_kp));
      c.mit_damping = 20'($urandom_range(0, lim_kd));
    end
    return c;
  endfunction

  task automatic wait_drain();
    while (cmd_q.size() > 0 || in_valid || frame_q.size() > 0) @(posedge clk);
    repeat (mcce_pkg::LATENCY + 6) @(posedge clk);
  endtask

  task automatic write_limit(input mcce_pkg::reg_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mcce_pkg::REG_POSITION_LIMIT: lim_pos = val[22:0] == 0 ? 23'd1 : val[22:0];
      mcce_pkg::REG_VELOCITY_LIMIT: lim_vel = val[22:0] == 0 ? 23'd1 : val[22:0];
      mcce_pkg::REG_TORQUE_LIMIT:   lim_tor = val[22:0] == 0 ? 23'd1 : val[22:0];
      mcce_pkg::REG_STIFFNESS_MAX:  lim_kp = val[24:0] == 0 ? 25'd1 : val[24:0];
      default:                      lim_kd = val[19:0] == 0 ? 20'd1 : val[19:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] a, b, c, d, e);
    write_limit(mcce_pkg::REG_POSITION_LIMIT, a);
    write_limit(mcce_pkg::REG_VELOCITY_LIMIT, b);
    write_limit(mcce_pkg::REG_TORQUE_LIMIT, c);
    write_limit(mcce_pkg::REG_STIFFNESS_MAX, d);
    write_limit(mcce_pkg::REG_DAMPING_MAX, e);
  endtask

  initial begin
    mcce_pkg::in_word_t c;
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pause_send = 1'b0;
    in_acc = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    lim_pos = mcce_pkg::POSITION_LIMIT_RST;
    lim_vel = mcce_pkg::VELOCITY_LIMIT_RST;
    lim_tor = mcce_pkg::TORQUE_LIMIT_RST;
    lim_kp = mcce_pkg::STIFFNESS_MAX_RST;
    lim_kd = mcce_pkg::DAMPING_MAX_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every operation, field extremes, saturation, dropped index
    for (int op = 0; op < 8; op++) begin
      c = '0;
      c.operation = 3'(op);
      c.motor_slot = 4'(op % MOTORS);
      c.mode_sel = 2'(op % 4);
      c.mit_position = 24'h7FFFFF;
      c.mit_velocity = 24'h800000;
      c.mit_stiffness = '1;
      c.mit_torque = 24'h000100;
      c.target_position_word = 32'h1234_5678;
      c.target_velocity_word = 32'hFFFF_FFFF;
      cmd_q.push_back(c);
    end
    c = '0;
    c.operation = mcce_pkg::OP_MIT;
    c.mit_position = -24'sd819200;
    c.mit_velocity = 24'sd1966080;
    c.mit_damping = '1;
    c.mit_torque = 24'h800000;
    cmd_q.push_back(c);
    c.mit_position = '0;
    c.mit_velocity = -24'sd1966079;
    c.mit_stiffness = 25'd32767999;
    c.mit_damping = 20'd327680;
    c.mit_torque = 24'sd655359;
    cmd_q.push_back(c);
    for (int m = MOTORS; m < 16; m += 3) begin
      c = '0;
      c.operation = 3'(m % 8);
      c.motor_slot = 4'(m);
      c.mode_sel = 2'd0;
      cmd_q.push_back(c);
    end
    c.operation = mcce_pkg::OP_MODE_CHANGE;
    c.motor_slot = 4'd15;
    cmd_q.push_back(c);
    c.motor_slot = 4'(MOTORS - 1);
    cmd_q.push_back(c);
    wait_drain();

    write_all(32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h1FFFFFF, 32'hFFFFF);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      case (phase)
        1: write_all(32'd1, 32'd0, 32'd1, 32'd1, 32'd0);
        2: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        3: write_all(mcce_pkg::POSITION_LIMIT_RST, mcce_pkg::VELOCITY_LIMIT_RST,
                     mcce_pkg::TORQUE_LIMIT_RST, mcce_pkg::STIFFNESS_MAX_RST,
                     mcce_pkg::DAMPING_MAX_RST);
        default: ;
      endcase
      for (int k = 0; k < 112; k++) begin
        cmd_q.push_back(rand_cmd($urandom_range(9) != 0));
        if (k == 60) begin
          while (cmd_q.size() > 0 || in_valid) @(posedge clk);
          pause_send = 1'b1;
          while (frame_q.size() > 0) @(posedge clk);
          pause_send = 1'b0;
        end
        if (k % 20 == 19) begin
          while (cmd_q.size() > 8) @(posedge clk);
        end
      end
      wait_drain();
    end

    if (errors == 0) begin
      $display("motor_can_command_encoder_top verification clean");
    end else begin
      $display("motor_can_command_encoder_top verification failed");
    end
    $finish;
  end
endmodule

// ===== motor_can_command_encoder_top.f =====
+incdir+rtl/core
rtl/core/mcce_pkg.sv
rtl/core/mcce_lane.sv
rtl/core/mcce_framer.sv
rtl/core/motor_can_command_encoder_top.sv
verif/motor_can_command_encoder_top_test.sv
